[design/gf2gt_pkg.sv]
// Shared types and codes for the GF(2) grease table builder.
`default_nettype none

package gf2gt_pkg;

    // Request opcodes.
    localparam logic [1:0] OP_START = 2'd0;
    localparam logic [1:0] OP_LOAD  = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;

    // Width of one stored word.
    localparam int WORD_W = 64;

    // Sequencer states.
    typedef enum logic {
        SEQ_IDLE,
        SEQ_READ
    } seq_state_t;

    // Per-word control that travels from the sequencer to the XOR combiner.
    typedef struct packed {
        logic issue;
        logic last;
        logic nz;
    } gf2gt_issue_t;

endpackage

`default_nettype wire

[design/gf2gt_bank.sv]
// One bank of base row words: one write port, one registered read port.
`default_nettype none

module gf2gt_bank #(
    parameter int DEPTH = 128,
    parameter int AW    = 7
) (
    input  wire logic                          clk,
    input  wire logic                          wr_en,
    input  wire logic [AW-1:0]                 wr_addr,
    input  wire logic [gf2gt_pkg::WORD_W-1:0]  wr_data,
    input  wire logic                          rd_en,
    input  wire logic [AW-1:0]                 rd_addr,
    output logic      [gf2gt_pkg::WORD_W-1:0]  rd_data
);

    logic [gf2gt_pkg::WORD_W-1:0] mem [DEPTH];
    logic [gf2gt_pkg::WORD_W-1:0] rd_data_reg;

    // Write port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read port; the data register holds while no read is enabled.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

[design/gf2gt_seq.sv]
// Request decode, nonzero flag and word sequencer for table row reads.
`default_nettype none

module gf2gt_seq #(
    parameter int SLICES        = 16,
    parameter int GREASE_LEVEL  = 8,
    parameter int WORDS_PER_ROW = 8,
    parameter int SL_W          = 4,
    parameter int WD_W          = 3,
    parameter int AW            = 7
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire logic [1:0]                    opcode,
    input  wire logic [3:0]                    slice,
    input  wire logic [7:0]                    row_index,
    input  wire logic [2:0]                    word_index,
    input  wire logic [gf2gt_pkg::WORD_W-1:0]  data_word,
    input  wire logic                          advance,
    output logic      [GREASE_LEVEL-1:0]       wr_en,
    output logic      [AW-1:0]                 wr_addr,
    output logic      [gf2gt_pkg::WORD_W-1:0]  wr_data,
    output logic      [AW-1:0]                 rd_addr,
    output gf2gt_pkg::gf2gt_issue_t            issue,
    output logic      [GREASE_LEVEL-1:0]       mask
);

    gf2gt_pkg::seq_state_t state_reg, state_next;
    logic [WD_W-1:0]         word_cnt_reg, word_cnt_next;
    logic [SL_W-1:0]         slice_idx_reg, slice_idx_next;
    logic [GREASE_LEVEL-1:0] mask_reg, mask_next;
    logic                    nz_item_reg, nz_item_next;
    logic                    nz_reg, nz_next;

    logic accept;
    logic slice_ok;
    logic word_ok;
    logic row_ok;
    logic load_ok;
    logic cnt_last;

    // The input is held off for the whole of a table row read.
    assign in_stall = state_reg != gf2gt_pkg::SEQ_IDLE;

    // Range checks on the request fields.
    assign accept   = in_valid && !in_stall;
    assign slice_ok = 32'(slice) < SLICES;
    assign word_ok  = 32'(word_index) < WORDS_PER_ROW;
    assign row_ok   = 32'(row_index) < GREASE_LEVEL;
    assign load_ok  = accept && (opcode == gf2gt_pkg::OP_LOAD) && slice_ok && word_ok;
    assign cnt_last = word_cnt_reg == WD_W'(WORDS_PER_ROW - 1);

    // Load requests write straight into the bank of their base row.
    assign wr_addr = AW'(SL_W'(slice) * WORDS_PER_ROW + WD_W'(word_index));
    assign wr_data = data_word;

    for (genvar g = 0; g < GREASE_LEVEL; g++)
    begin : g_wr
        assign wr_en[g] = load_ok && (row_index == 8'(g));
    end

    // Read issue toward the banks and the combiner.
    assign rd_addr     = AW'(slice_idx_reg * WORDS_PER_ROW + word_cnt_reg);
    assign issue.issue = state_reg == gf2gt_pkg::SEQ_READ;
    assign issue.last  = cnt_last;
    assign issue.nz    = nz_item_reg;
    assign mask        = mask_reg;

    // Next state and request handling.
    always_comb
    begin
        state_next     = state_reg;
        word_cnt_next  = word_cnt_reg;
        slice_idx_next = slice_idx_reg;
        mask_next      = mask_reg;
        nz_item_next   = nz_item_reg;
        nz_next        = nz_reg;
        case (state_reg)
            gf2gt_pkg::SEQ_IDLE:
            begin
                if (accept)
                begin
                    case (opcode)
                        gf2gt_pkg::OP_START:
                        begin
                            nz_next = 1'b0;
                        end
                        gf2gt_pkg::OP_LOAD:
                        begin
                            if (load_ok && row_ok && (data_word != '0))
                            begin
                                nz_next = 1'b1;
                            end
                        end
                        gf2gt_pkg::OP_READ:
                        begin
                            // An out-of-range slice reads as all-zero words.
                            slice_idx_next = SL_W'(slice);
                            mask_next      = slice_ok ? row_index[GREASE_LEVEL-1:0] : '0;
                            nz_item_next   = nz_reg;
                            word_cnt_next  = '0;
                            state_next     = gf2gt_pkg::SEQ_READ;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            gf2gt_pkg::SEQ_READ:
            begin
                if (advance)
                begin
                    if (cnt_last)
                    begin
                        state_next = gf2gt_pkg::SEQ_IDLE;
                    end
                    else
                    begin
                        word_cnt_next = word_cnt_reg + 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = gf2gt_pkg::SEQ_IDLE;
            end
        endcase
    end

    // State registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= gf2gt_pkg::SEQ_IDLE;
            word_cnt_reg  <= '0;
            nz_reg        <= 1'b0;
            slice_idx_reg <= '0;
            mask_reg      <= '0;
            nz_item_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            word_cnt_reg  <= word_cnt_next;
            nz_reg        <= nz_next;
            slice_idx_reg <= slice_idx_next;
            mask_reg      <= mask_next;
            nz_item_reg   <= nz_item_next;
        end
    end

endmodule

`default_nettype wire

[design/gf2gt_combine.sv]
// Shared XOR combiner over the bank read data, with the output register.
`default_nettype none

module gf2gt_combine #(
    parameter int GREASE_LEVEL = 8
) (
    input  wire logic                                          clk,
    input  wire logic                                          rst_n,
    input  wire gf2gt_pkg::gf2gt_issue_t                       issue,
    input  wire logic [GREASE_LEVEL-1:0]                       mask,
    input  wire logic [GREASE_LEVEL-1:0][gf2gt_pkg::WORD_W-1:0] bank_data,
    output logic                                               advance,
    output logic                                               out_valid,
    input  wire logic                                          out_stall,
    output logic      [gf2gt_pkg::WORD_W-1:0]                  table_word,
    output logic                                               last_word,
    output logic                                               brick_nonzero
);

    logic                         rd_valid_reg;
    logic                         rd_last_reg;
    logic                         rd_nz_reg;
    logic [GREASE_LEVEL-1:0]      rd_mask_reg;
    logic                         out_valid_reg;
    logic [gf2gt_pkg::WORD_W-1:0] out_word_reg;
    logic                         out_last_reg;
    logic                         out_nz_reg;
    logic [gf2gt_pkg::WORD_W-1:0] xor_word;

    // The pipeline moves whenever the output register is free or being taken.
    assign advance = !out_valid_reg || !out_stall;

    // XOR of the selected base row words.
    always_comb
    begin
        xor_word = '0;
        for (int g = 0; g < GREASE_LEVEL; g++)
        begin
            if (rd_mask_reg[g])
            begin
                xor_word = xor_word ^ bank_data[g];
            end
        end
    end

    // Valid flags of the read stage and the output stage.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            rd_valid_reg  <= issue.issue;
            out_valid_reg <= rd_valid_reg;
        end
    end

    // Word control alongside the bank read, then the result itself.
    always_ff @(posedge clk)
    begin
        if (advance && issue.issue)
        begin
            rd_last_reg <= issue.last;
            rd_nz_reg   <= issue.nz;
            rd_mask_reg <= mask;
        end
        if (advance && rd_valid_reg)
        begin
            out_word_reg <= xor_word;
            out_last_reg <= rd_last_reg;
            out_nz_reg   <= rd_nz_reg;
        end
    end

    assign out_valid     = out_valid_reg;
    assign table_word    = out_word_reg;
    assign last_word     = out_last_reg;
    assign brick_nonzero = out_nz_reg;

endmodule

`default_nettype wire

[design/gf2_grease_table_builder_core.sv]
// Top level of the GF(2) grease table builder: banks, sequencer and XOR combiner.
//
// Builds four-Russians grease table rows over GF(2). A start request clears the
// brick's nonzero flag; a load request writes one 64-bit base row word into the
// bank of its base row. A read request names a slice and a combination index and
// returns WORDS_PER_ROW words, each the XOR of the base rows whose index bits are
// set, with last_word on the final word and the brick's nonzero flag at the time
// of the read on every word. The base rows sit in GREASE_LEVEL banks read in
// parallel, so one combined word leaves per cycle while the output is not stalled;
// a read holds off further requests until the sequencer has issued its last word,
// and issuing waits while the output is stalled.
// Words of base rows that were never loaded read back as unknown data.
`default_nettype none

module gf2_grease_table_builder_core #(
    parameter int SLICES        = 16,
    parameter int GREASE_LEVEL  = 8,
    parameter int WORDS_PER_ROW = 8
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire logic [1:0]                    opcode,
    input  wire logic [3:0]                    slice,
    input  wire logic [7:0]                    row_index,
    input  wire logic [2:0]                    word_index,
    input  wire logic [gf2gt_pkg::WORD_W-1:0]  data_word,
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic      [gf2gt_pkg::WORD_W-1:0]  table_word,
    output logic                               last_word,
    output logic                               brick_nonzero
);

    localparam int SL_W       = (SLICES > 1) ? $clog2(SLICES) : 1;
    localparam int WD_W       = (WORDS_PER_ROW > 1) ? $clog2(WORDS_PER_ROW) : 1;
    localparam int BANK_DEPTH = SLICES * WORDS_PER_ROW;
    localparam int AW         = $clog2(BANK_DEPTH);

    logic [GREASE_LEVEL-1:0]                       bank_wr_en;
    logic [AW-1:0]                                 wr_addr;
    logic [gf2gt_pkg::WORD_W-1:0]                  wr_data;
    logic [AW-1:0]                                 rd_addr;
    logic                                          rd_en;
    logic                                          advance;
    gf2gt_pkg::gf2gt_issue_t                       issue;
    logic [GREASE_LEVEL-1:0]                       mask;
    logic [GREASE_LEVEL-1:0][gf2gt_pkg::WORD_W-1:0] bank_data;

    // Request decode and word sequencing.
    gf2gt_seq #(
        .SLICES        (SLICES),
        .GREASE_LEVEL  (GREASE_LEVEL),
        .WORDS_PER_ROW (WORDS_PER_ROW),
        .SL_W          (SL_W),
        .WD_W          (WD_W),
        .AW            (AW)
    ) u_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .opcode     (opcode),
        .slice      (slice),
        .row_index  (row_index),
        .word_index (word_index),
        .data_word  (data_word),
        .advance    (advance),
        .wr_en      (bank_wr_en),
        .wr_addr    (wr_addr),
        .wr_data    (wr_data),
        .rd_addr    (rd_addr),
        .issue      (issue),
        .mask       (mask)
    );

    // A bank read happens only when the combiner can take its data.
    assign rd_en = issue.issue && advance;

    // One bank per base row.
    for (genvar g = 0; g < GREASE_LEVEL; g++)
    begin : g_bank
        gf2gt_bank #(
            .DEPTH (BANK_DEPTH),
            .AW    (AW)
        ) u_bank (
            .clk     (clk),
            .wr_en   (bank_wr_en[g]),
            .wr_addr (wr_addr),
            .wr_data (wr_data),
            .rd_en   (rd_en),
            .rd_addr (rd_addr),
            .rd_data (bank_data[g])
        );
    end

    // XOR combiner and output register.
    gf2gt_combine #(
        .GREASE_LEVEL (GREASE_LEVEL)
    ) u_combine (
        .clk           (clk),
        .rst_n         (rst_n),
        .issue         (issue),
        .mask          (mask),
        .bank_data     (bank_data),
        .advance       (advance),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .table_word    (table_word),
        .last_word     (last_word),
        .brick_nonzero (brick_nonzero)
    );

`ifndef NO_ASSERTIONS
    // A load writes at most one bank.
    assert property (@(posedge clk) disable iff (!rst_n) $onehot0(bank_wr_en))
        else $error("more than one bank written in a cycle");

    // No bank is written while a table row is being read out.
    assert property (@(posedge clk) disable iff (!rst_n) (|bank_wr_en) |-> !issue.issue)
        else $error("bank write during a table row read");

    // A word that could not be issued keeps its read address.
    assert property (@(posedge clk) disable iff (!rst_n)
        (issue.issue && !advance) |=> (issue.issue && $stable(rd_addr)))
        else $error("read address moved while the output was stalled");
`endif

endmodule

`default_nettype wire

[sim/tb.sv]
// Self-checking testbench for the GF(2) grease table builder core.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SLICES        = 16;
    localparam int GREASE_LEVEL  = 8;
    localparam int WORDS_PER_ROW = 8;
    localparam int WORD_W        = gf2gt_pkg::WORD_W;
    localparam int RANDOM_REQS   = 430;
    localparam int HOLD_AT       = 40;
    localparam int HOLD_CYCLES   = 200;
    localparam logic [1:0] OP_NOP = 2'd3;

    typedef struct {
        logic [1:0]        op;
        logic [3:0]        slc;
        logic [7:0]        row;
        logic [2:0]        word;
        logic [WORD_W-1:0] data;
    } request_t;

    typedef struct {
        logic [WORD_W-1:0] word;
        logic              last;
        logic              nz;
    } table_word_t;

    logic              clk;
    logic              rst_n;
    logic              in_valid;
    logic              in_stall;
    logic [1:0]        opcode;
    logic [3:0]        slice;
    logic [7:0]        row_index;
    logic [2:0]        word_index;
    logic [WORD_W-1:0] data_word;
    logic              out_valid;
    logic              out_stall;
    logic [WORD_W-1:0] table_word;
    logic              last_word;
    logic              brick_nonzero;

    // Stimulus queue, expected table words and bookkeeping.
    request_t    pending_reqs[$];
    table_word_t expected_words[$];
    request_t    drive_req;
    int          total_reqs;
    int          accepted_cnt;
    int          err_cnt;
    int          hold_left;
    bit          hold_done;
    bit          in_taken;

    // Predictor state: the base row store and the brick nonzero flag.
    logic [WORD_W-1:0] base_store [SLICES][GREASE_LEVEL][WORDS_PER_ROW];
    logic              brick_nz;

    // Which base words the generated stream has written so far.
    bit loaded_map [SLICES][GREASE_LEVEL][WORDS_PER_ROW];

    gf2_grease_table_builder_core #(
        .SLICES       (SLICES),
        .GREASE_LEVEL (GREASE_LEVEL),
        .WORDS_PER_ROW(WORDS_PER_ROW)
    ) uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .opcode       (opcode),
        .slice        (slice),
        .row_index    (row_index),
        .word_index   (word_index),
        .data_word    (data_word),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .table_word   (table_word),
        .last_word    (last_word),
        .brick_nonzero(brick_nonzero)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Hard limit on run length.
    initial
    begin
        #2_000_000;
        $display("TB_ERROR");
        $finish;
    end

    // Idling phase follows progress through the request stream.
    function automatic int phase_now();
        if (total_reqs == 0)
            return 0;
        return (accepted_cnt * 4) / total_reqs;
    endfunction

    function automatic int sender_idle_pct();
        case (phase_now())
            1:       return 86;
            3:       return 8;
            default: return 0;
        endcase
    endfunction

    function automatic int receiver_stall_pct();
        case (phase_now())
            2:       return 86;
            3:       return 8;
            default: return 0;
        endcase
    endfunction

    // Queue one request and track which base words it writes.
    function automatic void add_req(input logic [1:0] op, input int s, input int r,
                                    input int w, input logic [WORD_W-1:0] d);
        request_t q;
        q.op   = op;
        q.slc  = s[3:0];
        q.row  = r[7:0];
        q.word = w[2:0];
        q.data = d;
        pending_reqs.push_back(q);
        if (op == gf2gt_pkg::OP_LOAD && r < GREASE_LEVEL && s < SLICES && w < WORDS_PER_ROW)
            loaded_map[s][r][w] = 1'b1;
    endfunction

    // Base rows of a slice whose words are all written.
    function automatic logic [7:0] ready_rows(input int s);
        logic [7:0] mask;
        mask = '0;
        for (int r = 0; r < GREASE_LEVEL; r++)
        begin
            mask[r] = 1'b1;
            for (int w = 0; w < WORDS_PER_ROW; w++)
                if (!loaded_map[s][r][w])
                    mask[r] = 1'b0;
        end
        return mask;
    endfunction

    // Data words with a bias toward zero, all ones and single bits.
    function automatic logic [WORD_W-1:0] rand_word();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            2:       return 64'd1 << $urandom_range(0, 63);
            default: return {$urandom, $urandom};
        endcase
    endfunction

    function automatic int pick_slice();
        if ($urandom_range(0, 3) == 0)
            return $urandom_range(0, SLICES - 1);
        return $urandom_range(0, 3);
    endfunction

    // Apply one accepted request to the predictor and queue its table words.
    task automatic predict_request(input logic [1:0] op, input logic [3:0] s,
                                   input logic [7:0] r, input logic [2:0] w,
                                   input logic [WORD_W-1:0] d);
        table_word_t e;
        logic [WORD_W-1:0] acc;
        case (op)
            gf2gt_pkg::OP_START:
                brick_nz = 1'b0;
            gf2gt_pkg::OP_LOAD:
                if (s < SLICES && r < GREASE_LEVEL && w < WORDS_PER_ROW)
                begin
                    base_store[s][r[2:0]][w] = d;
                    if (d != '0)
                        brick_nz = 1'b1;
                end
            gf2gt_pkg::OP_READ:
                for (int wi = 0; wi < WORDS_PER_ROW; wi++)
                begin
                    acc = '0;
                    if (s < SLICES)
                        for (int ri = 0; ri < GREASE_LEVEL; ri++)
                            if (r[ri])
                                acc ^= base_store[s][ri][wi];
                    e.word = acc;
                    e.last = (wi == WORDS_PER_ROW - 1);
                    e.nz   = brick_nz;
                    expected_words.push_back(e);
                end
            default:
                ;
        endcase
    endtask

    task automatic report_mismatch(input string what, input logic [WORD_W-1:0] got,
                                   input logic [WORD_W-1:0] want);
        $display("mismatch on %s: got %h, expected %h at %0t ns", what, got, want, $time);
        err_cnt++;
    endtask

    // Requests accepted at the rising edge feed the predictor.
    always @(posedge clk)
    begin
        if (rst_n && in_valid && !in_stall)
        begin
            predict_request(opcode, slice, row_index, word_index, data_word);
            accepted_cnt++;
            in_taken = 1'b1;
        end
    end

    // Driver: presents the next request at the falling edge, with random idling.
    always @(negedge clk)
    begin
        if (rst_n && (!in_valid || in_taken))
        begin
            in_taken = 1'b0;
            if (pending_reqs.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct())
            begin
                drive_req = pending_reqs.pop_front();
                in_valid   <= 1'b1;
                opcode     <= drive_req.op;
                slice      <= drive_req.slc;
                row_index  <= drive_req.row;
                word_index <= drive_req.word;
                data_word  <= drive_req.data;
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    // Receiver stall, including one long hold-off while the sender keeps going.
    always @(negedge clk)
    begin
        if (!hold_done && accepted_cnt >= HOLD_AT)
        begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_stall <= 1'b1;
        end
        else
        begin
            out_stall <= ($urandom_range(0, 99) < receiver_stall_pct());
        end
    end

    // Monitor: compare each accepted table word with the oldest expectation.
    always @(posedge clk)
    begin
        table_word_t e;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_words.size() == 0)
            begin
                report_mismatch("unexpected table word", table_word, '0);
            end
            else
            begin
                e = expected_words.pop_front();
                if (table_word !== e.word)
                    report_mismatch("table_word", table_word, e.word);
                if (last_word !== e.last)
                    report_mismatch("last_word", WORD_W'(last_word), WORD_W'(e.last));
                if (brick_nonzero !== e.nz)
                    report_mismatch("brick_nonzero", WORD_W'(brick_nonzero), WORD_W'(e.nz));
            end
        end
    end

    initial
    begin
        int rand_cnt;
        int s;
        int r;
        int k;
        logic [7:0] mask;
        logic [7:0] idx;

        rst_n        = 1'b0;
        in_valid     = 1'b0;
        opcode       = gf2gt_pkg::OP_START;
        slice        = '0;
        row_index    = '0;
        word_index   = '0;
        data_word    = '0;
        out_stall    = 1'b0;
        accepted_cnt = 0;
        err_cnt      = 0;
        hold_left    = 0;
        hold_done    = 1'b0;
        in_taken     = 1'b0;
        brick_nz     = 1'b0;
        total_reqs   = 0;
        foreach (loaded_map[a, b, c])
            loaded_map[a][b][c] = 1'b0;

        // Directed: index zero, all-zero loads keep the flag clear, ignored
        // loads and the no-op leave it clear, then extreme words and a start.
        add_req(gf2gt_pkg::OP_START, 0, 0, 0, '0);
        add_req(gf2gt_pkg::OP_READ, 15, 0, 0, '1);
        for (int w = 0; w < WORDS_PER_ROW; w++)
            add_req(gf2gt_pkg::OP_LOAD, 0, 0, w, '0);
        add_req(gf2gt_pkg::OP_LOAD, 3, GREASE_LEVEL, 0, '1);
        add_req(gf2gt_pkg::OP_LOAD, 3, 255, 7, '1);
        add_req(OP_NOP, 15, 255, 7, '1);
        add_req(gf2gt_pkg::OP_READ, 0, 1, 0, '0);
        add_req(gf2gt_pkg::OP_LOAD, 15, 7, 0, '1);
        add_req(gf2gt_pkg::OP_LOAD, 15, 7, 1, 64'h8000_0000_0000_0000);
        add_req(gf2gt_pkg::OP_LOAD, 15, 7, 2, 64'd1);
        for (int w = 3; w < WORDS_PER_ROW; w++)
            add_req(gf2gt_pkg::OP_LOAD, 15, 7, w, rand_word());
        add_req(gf2gt_pkg::OP_READ, 15, 8'h80, 0, '0);
        add_req(gf2gt_pkg::OP_START, 15, 255, 7, '1);
        add_req(gf2gt_pkg::OP_READ, 15, 8'h80, 7, '1);

        // Random: mostly whole base row fills followed by reads of ready rows,
        // with starts, stray loads and ignored requests mixed in.
        rand_cnt = 0;
        while (rand_cnt < RANDOM_REQS)
        begin
            k = $urandom_range(0, 99);
            if (k < 4)
            begin
                add_req(gf2gt_pkg::OP_START, $urandom_range(0, 15), $urandom_range(0, 255),
                        $urandom_range(0, 7), rand_word());
                rand_cnt++;
            end
            else if (k < 10)
            begin
                // Ignored: no-op or a load beyond the last base row.
                if ($urandom_range(0, 1) == 0)
                    add_req(OP_NOP, $urandom_range(0, 15), $urandom_range(0, 255),
                            $urandom_range(0, 7), rand_word());
                else
                    add_req(gf2gt_pkg::OP_LOAD, $urandom_range(0, 15),
                            $urandom_range(GREASE_LEVEL, 255), $urandom_range(0, 7),
                            rand_word());
            end
            else if (k < 30)
            begin
                s = pick_slice();
                r = $urandom_range(0, GREASE_LEVEL - 1);
                k = $urandom_range(0, WORDS_PER_ROW - 1);
                for (int w = 0; w < WORDS_PER_ROW; w++)
                    add_req(gf2gt_pkg::OP_LOAD, s, r, (w + k) % WORDS_PER_ROW, rand_word());
                rand_cnt += WORDS_PER_ROW;
            end
            else if (k < 35)
            begin
                add_req(gf2gt_pkg::OP_LOAD, pick_slice(),
                        $urandom_range(0, GREASE_LEVEL - 1),
                        $urandom_range(0, WORDS_PER_ROW - 1), rand_word());
                rand_cnt++;
            end
            else
            begin
                s = pick_slice();
                for (int t = 0; t < 4 && ready_rows(s) == '0; t++)
                    s = pick_slice();
                mask = ready_rows(s);
                case ($urandom_range(0, 5))
                    0:       idx = '0;
                    1:       idx = mask;
                    default: idx = 8'($urandom) & mask;
                endcase
                add_req(gf2gt_pkg::OP_READ, s, int'(idx), $urandom_range(0, 7), rand_word());
                rand_cnt++;
            end
        end
        total_reqs = pending_reqs.size();

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Drain: every request accepted, every table word returned, then settle.
        while (accepted_cnt < total_reqs)
            @(negedge clk);
        while (expected_words.size() != 0)
            @(negedge clk);
        repeat (4 * WORDS_PER_ROW) @(negedge clk);

        if (err_cnt == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end
endmodule
